### sv/md5_pkg.sv
// Shared types, constants and round tables for the MD5 stream hasher.
package md5_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  // Front-end item passed to the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } md5_item_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_rot(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index used by round r.
  function automatic logic [3:0] round_g(input logic [5:0] r);
    logic [3:0] g;
    unique case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = 4'(5 * r[3:0] + 1);
      2'd2: g = 4'(3 * r[3:0] + 5);
      default: g = 4'(7 * r[3:0]);
    endcase
    return g;
  endfunction

endpackage

### sv/md5_fifo.sv
// Short item queue between the input front end and the hashing back end.
module md5_fifo #(
  parameter int unsigned Depth = md5_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  md5_pkg::md5_item_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output md5_pkg::md5_item_t pop_data_o,
  output logic              empty_o
);
  import md5_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  md5_item_t        mem_q [Depth];
  logic [Aw-1:0]    wptr_q, rptr_q;
  logic [Aw:0]      cnt_q;

  assign full_o     = (cnt_q == (Aw+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o)
        wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i && !empty_o)
        rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i && !full_o) - (Aw+1)'(pop_i && !empty_o);
    end
  end
endmodule

### sv/md5_core.sv
// Back end: block buffer, length count, padding and iterative 64-round compression.
module md5_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  md5_pkg::md5_item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_word_o,
  output logic [1:0]         out_index_o
);
  import md5_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRun  = 3'd1;
  localparam logic [2:0] StPad  = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0]  state_q, state_d;
  // block buffer split into four byte lanes of 16 bytes each
  logic [7:0]  blk0_q [16];
  logic [7:0]  blk1_q [16];
  logic [7:0]  blk2_q [16];
  logic [7:0]  blk3_q [16];
  logic [60:0] cnt_q;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  rnd_q;
  logic        fin_q;      // compression belongs to the final padding
  logic        more_q;     // a second padded block follows
  logic [5:0]  pad_q;      // pad sweep position
  logic [1:0]  oidx_q;

  logic [31:0] f, mg, sum, rot, nb;
  logic [3:0]  g;
  logic [4:0]  s;
  logic [63:0] bits;
  logic        blk_we;
  logic [5:0]  blk_wa;
  logic [7:0]  blk_wd;

  assign bits = {cnt_q, 3'b000};
  assign g    = round_g(rnd_q);
  assign s    = round_rot(rnd_q);
  assign mg   = {blk3_q[g], blk2_q[g], blk1_q[g], blk0_q[g]};

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign sum = a_q + f + round_k(rnd_q) + mg;
  assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  assign nb  = b_q + rot;

  assign item_pop_o  = (state_q == StIdle) && item_valid_i;
  assign out_valid_o = (state_q == StOut);
  assign out_word_o  = h_q[oidx_q];
  assign out_index_o = oidx_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (item_valid_i) begin
        if (item_i.has && cnt_q[5:0] == 6'd63) state_d = StRun;
        else if (item_i.last) state_d = StPad;
      end
      StRun: if (rnd_q == 6'd63) begin
        if (fin_q) state_d = more_q ? StPad : StOut;
        else state_d = StIdle;
      end
      StPad: if (pad_q == 6'd63) state_d = StRun;
      StOut: if (out_ready_i && oidx_q == 2'd3) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    blk_we = 1'b0;
    blk_wa = pad_q;
    blk_wd = 8'h00;
    if (state_q == StIdle && item_valid_i && item_i.has) begin
      blk_we = 1'b1;
      blk_wa = cnt_q[5:0];
      blk_wd = item_i.data;
    end else if (state_q == StPad) begin
      // pad_q walks from its start (the first free byte, or byte zero on a second pass) to the end of the block
      blk_we = 1'b1;
      if (more_q) blk_wd = (pad_q == cnt_q[5:0]) ? PadByte : 8'h00;
      else if (pad_q >= 6'd56) blk_wd = bits[{pad_q[2:0], 3'b000} +: 8];
      else if (pad_q == cnt_q[5:0] && fin_q) blk_wd = PadByte;
      else blk_wd = 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      unique case (blk_wa[1:0])
        2'd0: blk0_q[blk_wa[5:2]] <= blk_wd;
        2'd1: blk1_q[blk_wa[5:2]] <= blk_wd;
        2'd2: blk2_q[blk_wa[5:2]] <= blk_wd;
        2'd3: blk3_q[blk_wa[5:2]] <= blk_wd;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      h_q[0]  <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      rnd_q <= '0; fin_q <= 1'b0; more_q <= 1'b0; pad_q <= '0; oidx_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: if (item_valid_i) begin
          rnd_q <= '0;
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
          if (item_i.has) cnt_q <= cnt_q + 61'd1;
          // fin_q: final pass pending; more_q: padding will need two blocks
          fin_q  <= item_i.last;
          more_q <= 1'b0;
          if (item_i.last) begin
            if (item_i.has && cnt_q[5:0] == 6'd63) begin
              // full block first, then a block of the 0x80 marker, zeros and length
              more_q <= 1'b1;
              pad_q  <= '0;
            end else begin
              pad_q  <= item_i.has ? cnt_q[5:0] + 6'd1 : cnt_q[5:0];
              more_q <= ((item_i.has ? cnt_q[5:0] + 6'd1 : cnt_q[5:0]) >= 6'd56);
            end
          end
        end
        StRun: begin
          a_q <= d_q; b_q <= nb; c_q <= b_q; d_q <= c_q;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            h_q[0] <= h_q[0] + d_q; h_q[1] <= h_q[1] + nb;
            h_q[2] <= h_q[2] + b_q; h_q[3] <= h_q[3] + c_q;
            if (fin_q && more_q) begin
              more_q <= 1'b0;
              // second pass: 0x80 only if it was not already placed
              pad_q  <= '0;
              fin_q  <= (cnt_q[5:0] == 6'd0);
            end
            oidx_q <= '0;
          end
        end
        StPad: begin
          pad_q <= pad_q + 6'd1;
          if (pad_q == 6'd63) begin
            rnd_q <= '0;
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
            if (more_q) fin_q <= 1'b1;
            else fin_q <= 1'b1;
            oidx_q <= '0;
          end
        end
        StOut: if (out_ready_i) begin
          oidx_q <= oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
            cnt_q  <= '0;
            fin_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### sv/md5_stream_hasher.sv
// MD5 stream hasher top level: input queue front end and compression back end.
// One byte per transfer enters a FifoDepth-entry queue (four by default). The back end
// takes one queued item per cycle while idle; a byte that fills a 64-byte block then
// holds it for the compression, one round per cycle. A last transfer starts a padding
// sweep from the first free byte to the end of the block (after any full-block
// compression), then 64 rounds; when the 0x80 marker and the length do not both fit,
// a second sweep of zeros and length and 64 more rounds follow. The four digest
// transfers then leave one per cycle while m_axis_tready is high. Bytes wait in the
// queue while the shared round unit compresses a block from the block buffer it reads,
// and during padding and digest output.
module md5_stream_hasher #(
  parameter int unsigned FifoDepth = md5_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[33:32], zeros
  output logic        m_axis_tlast    // last_word
);
  import md5_pkg::*;

  md5_item_t in_item, q_item;
  logic full, empty, pop;
  logic [31:0] word;
  logic [1:0]  idx;

  assign in_item = '{data: s_axis_tdata, has: s_axis_tuser, last: s_axis_tlast};
  assign s_axis_tready = !full;

  md5_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(s_axis_tvalid), .push_data_i(in_item), .full_o(full),
    .pop_i(pop), .pop_data_o(q_item), .empty_o(empty)
  );

  md5_core u_core (
    .clk_i, .rst_ni,
    .item_valid_i(!empty), .item_i(q_item), .item_pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(word), .out_index_o(idx)
  );

  assign m_axis_tdata = {6'd0, idx, word};
  assign m_axis_tlast = (idx == 2'd3);
endmodule

### sv/md5_checker.sv
// Port-level checker for the MD5 stream hasher, bound to the top level.
module md5_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped while stalled");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[33:32] == 2'd3)))
    else $error("tlast not on word 3");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[33:32] == $past(m_axis_tdata[33:32]) + 2'd1)
    else $error("digest words not consecutive");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
    else $error("pad bits set");
endmodule

bind md5_stream_hasher md5_checker u_md5_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
